// ===== rtl/sdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, constants and helpers of the SCARA dynamics terms unit.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int unsigned      CORDIC_STAGES_DEFAULT = 16;
  localparam logic [19:0]      GRAVITY_Q16_DEFAULT   = 20'd642908;

  // Angles in Q4.28 radians
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;

  typedef enum logic [2:0] {
    REG_LINK1_LENGTH = 3'd0,
    REG_LINK2_LENGTH = 3'd1,
    REG_MASS_ONE     = 3'd2,
    REG_MASS_TWO     = 3'd3,
    REG_MASS_THREE   = 3'd4,
    REG_MASS_FOUR    = 3'd5,
    REG_YAW_INERTIA  = 3'd6
  } sdt_reg_e;

  typedef struct packed {
    logic signed [15:0] joint2_angle;
    logic signed [15:0] joint1_rate;
    logic signed [15:0] joint2_rate;
  } sdt_in_t;

  typedef struct packed {
    logic signed [31:0] inertia_11;
    logic signed [31:0] inertia_22;
    logic signed [31:0] inertia_33;
    logic signed [31:0] inertia_44;
    logic signed [31:0] inertia_12;
    logic signed [31:0] inertia_14;
    logic signed [31:0] coriolis_11;
    logic signed [31:0] coriolis_21;
    logic signed [31:0] coriolis_12;
    logic signed [31:0] gravity_3;
  } sdt_out_t;

  typedef struct packed {
    logic signed [15:0] qd1;
    logic signed [15:0] qd2;
  } sdt_rates_t;

  // Terms that depend on the registers only
  typedef struct packed {
    logic [41:0]        t16;         // a1 a2 M, Q16
    logic [42:0]        r_one;       // diagonal sum for entry 1-1, Q15
    logic [41:0]        r_two;       // diagonal sum for entry 2-2, Q15
    logic signed [31:0] inertia_22;
    logic signed [31:0] inertia_33;
    logic signed [31:0] inertia_44;
    logic signed [31:0] inertia_14;
    logic signed [31:0] gravity_3;
  } sdt_coef_t;

  // atan(2^-i) in Q4.28, rounded
  function automatic logic signed [31:0] atan_q28(input int unsigned i);
    logic signed [31:0] a;
    case (i)
      0:       a = 32'sd210828714;
      1:       a = 32'sd124459457;
      2:       a = 32'sd65760959;
      3:       a = 32'sd33381290;
      4:       a = 32'sd16755422;
      5:       a = 32'sd8385879;
      6:       a = 32'sd4193963;
      7:       a = 32'sd2097109;
      8:       a = 32'sd1048571;
      9:       a = 32'sd524287;
      10:      a = 32'sd262144;
      11:      a = 32'sd131072;
      default: a = 32'sh1000_0000 >>> i;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sdt_coef.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_coef
// Configuration registers and the register-only terms, built over five
// register stages after each write.
// ----------------------------------------------------------------------------
module sdt_coef
  import sdt_pkg::*;
#(
  parameter logic [19:0] GRAVITY_Q16 = GRAVITY_Q16_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output sdt_coef_t        coef_o
);

  logic [15:0] a1_q, a2_q, m1_q, m2_q, m3_q, m4_q, izz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q  <= '0;
      a2_q  <= '0;
      m1_q  <= '0;
      m2_q  <= '0;
      m3_q  <= '0;
      m4_q  <= '0;
      izz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINK1_LENGTH: a1_q  <= cfg_wdata_i;
        REG_LINK2_LENGTH: a2_q  <= cfg_wdata_i;
        REG_MASS_ONE:     m1_q  <= cfg_wdata_i;
        REG_MASS_TWO:     m2_q  <= cfg_wdata_i;
        REG_MASS_THREE:   m3_q  <= cfg_wdata_i;
        REG_MASS_FOUR:    m4_q  <= cfg_wdata_i;
        REG_YAW_INERTIA:  izz_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage 1
  logic [31:0] a1a2_q, a1sq_q, a2sq_q;
  logic [17:0] msum_q, msum1_q;
  logic [16:0] m34_q;
  logic [37:0] grav_q;
  logic [15:0] izz1_q;
  // stage 2
  logic [49:0]        tfull_q, a2m_q, a1m_q;
  logic signed [31:0] g3_q;
  // stage 3
  logic [41:0] t16_q;
  logic [50:0] s_two_q;
  logic [49:0] a1m3_q;
  // stage 4
  logic [51:0] s_one_q;
  logic [41:0] r_two_q;
  // stage 5
  logic [42:0]        r_one_q;
  logic signed [31:0] i22_q;

  logic signed [38:0] gneg;
  assign gneg = 39'sd256 - $signed({1'b0, grav_q});

  always_ff @(posedge clk_i) begin
    a1a2_q  <= 32'(a1_q) * 32'(a2_q);
    a1sq_q  <= 32'(a1_q) * 32'(a1_q);
    a2sq_q  <= 32'(a2_q) * 32'(a2_q);
    msum_q  <= 18'(m2_q) + 18'(m3_q) + 18'(m4_q);
    msum1_q <= 18'(m1_q) + 18'(m2_q) + 18'(m3_q) + 18'(m4_q);
    m34_q   <= 17'(m3_q) + 17'(m4_q);
    grav_q  <= 38'(GRAVITY_Q16) * (38'(m3_q) + 38'({m4_q, 1'b0}));
    izz1_q  <= izz_q;

    tfull_q <= 50'(a1a2_q) * 50'(msum_q);
    a2m_q   <= 50'(a2sq_q) * 50'(msum_q);
    a1m_q   <= 50'(a1sq_q) * 50'(msum1_q);
    g3_q    <= 32'(gneg >>> 9);

    t16_q   <= 42'((51'(tfull_q) + 51'd128) >> 8);
    s_two_q <= 51'({izz1_q, 16'h0000}) + 51'(a2m_q);
    a1m3_q  <= a1m_q;

    s_one_q <= 52'(s_two_q) + 52'(a1m3_q);
    r_two_q <= 42'((s_two_q + 51'd256) >> 9);

    r_one_q <= 43'((s_one_q + 52'd256) >> 9);
    i22_q   <= sat32(64'(r_two_q));
  end

  assign coef_o.t16        = t16_q;
  assign coef_o.r_one      = r_one_q;
  assign coef_o.r_two      = r_two_q;
  assign coef_o.inertia_22 = i22_q;
  assign coef_o.inertia_33 = $signed(32'({m34_q, 7'b0}));
  assign coef_o.inertia_44 = $signed(32'({izz1_q, 7'b0}));
  assign coef_o.inertia_14 = -$signed(32'({izz1_q, 7'b0}));
  assign coef_o.gravity_3  = g3_q;

endmodule
`default_nettype wire

// ===== rtl/sdt_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_cordic
// Pipelined rotation CORDIC: range reduction, one stage per micro-rotation,
// rounding to Q16 sine and cosine.
// ----------------------------------------------------------------------------
module sdt_cordic
  import sdt_pkg::*;
#(
  parameter int unsigned STAGES = CORDIC_STAGES_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic signed [15:0] in_angle_i,
  input  sdt_rates_t              in_tag_i,
  output logic                    out_valid_o,
  output logic signed [17:0]      out_sin_o,
  output logic signed [17:0]      out_cos_o,
  output sdt_rates_t              out_tag_o
);

  logic signed [32:0] z_in, z_wrap;
  logic signed [31:0] wrap_z_q;
  logic               wrap_vld_q;
  sdt_rates_t         wrap_tag_q;

  assign z_in = 33'($signed({in_angle_i, 16'h0000}));

  always_comb begin
    if (z_in > PI_Q28) begin
      z_wrap = z_in - TWO_PI_Q28;
    end else if (z_in < -PI_Q28) begin
      z_wrap = z_in + TWO_PI_Q28;
    end else begin
      z_wrap = z_in;
    end
  end

  logic signed [31:0] x_q [STAGES+1];
  logic signed [31:0] y_q [STAGES+1];
  logic signed [31:0] z_q [STAGES+1];
  logic               flip_q [STAGES+1];
  sdt_rates_t         tag_q [STAGES+1];
  logic               vld_q [STAGES+1];

  logic signed [32:0] z_w33, z_fold;
  logic               flip_d;

  assign z_w33 = 33'(wrap_z_q);

  // reflect into the right half plane and negate the cosine
  always_comb begin
    flip_d = 1'b0;
    z_fold = z_w33;
    if (z_w33 > HALF_PI_Q28) begin
      z_fold = PI_Q28 - z_w33;
      flip_d = 1'b1;
    end else if (z_w33 < -HALF_PI_Q28) begin
      z_fold = -PI_Q28 - z_w33;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_vld_q <= 1'b0;
      vld_q[0]   <= 1'b0;
    end else begin
      wrap_vld_q <= in_valid_i;
      vld_q[0]   <= wrap_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_z_q   <= z_wrap[31:0];
    wrap_tag_q <= in_tag_i;
    x_q[0]     <= GAIN_Q28;
    y_q[0]     <= '0;
    z_q[0]     <= z_fold[31:0];
    flip_q[0]  <= flip_d;
    tag_q[0]   <= wrap_tag_q;
  end

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
    localparam logic signed [31:0] ATAN_I = atan_q28(gi);
    logic signed [31:0] dx, dy;

    assign dx = y_q[gi] >>> gi;
    assign dy = x_q[gi] >>> gi;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gi+1] <= 1'b0;
      end else begin
        vld_q[gi+1] <= vld_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z_q[gi][31]) begin
        x_q[gi+1] <= x_q[gi] - dx;
        y_q[gi+1] <= y_q[gi] + dy;
        z_q[gi+1] <= z_q[gi] - ATAN_I;
      end else begin
        x_q[gi+1] <= x_q[gi] + dx;
        y_q[gi+1] <= y_q[gi] - dy;
        z_q[gi+1] <= z_q[gi] + ATAN_I;
      end
      flip_q[gi+1] <= flip_q[gi];
      tag_q[gi+1]  <= tag_q[gi];
    end
  end

  logic signed [31:0] sin_r, cos_r;
  assign sin_r = (y_q[STAGES] + 32'sd2048) >>> 12;
  assign cos_r = (x_q[STAGES] + 32'sd2048) >>> 12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= vld_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    out_sin_o <= sin_r[17:0];
    out_cos_o <= flip_q[STAGES] ? -cos_r[17:0] : cos_r[17:0];
    out_tag_o <= tag_q[STAGES];
  end

endmodule
`default_nettype wire

// ===== rtl/sdt_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_mult
// Six-stage product pipeline: a1 a2 M times sine and cosine, then times the
// joint rates, rounding and saturation. Wide products are split in halves.
// ----------------------------------------------------------------------------
module sdt_mult
  import sdt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic signed [17:0] in_sin_i,
  input  wire logic signed [17:0] in_cos_i,
  input  sdt_rates_t              in_tag_i,
  input  sdt_coef_t               coef_i,
  output logic                    out_valid_o,
  output sdt_out_t                out_o
);

  logic m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q, m5_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q    <= 1'b0;
      m2_vld_q    <= 1'b0;
      m3_vld_q    <= 1'b0;
      m4_vld_q    <= 1'b0;
      m5_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      m1_vld_q    <= in_valid_i;
      m2_vld_q    <= m1_vld_q;
      m3_vld_q    <= m2_vld_q;
      m4_vld_q    <= m3_vld_q;
      m5_vld_q    <= m4_vld_q;
      out_valid_o <= m5_vld_q;
    end
  end

  // stage 1: half products of a1 a2 M with cosine and sine
  logic signed [21:0] t_lo, t_hi;
  assign t_lo = $signed({1'b0, coef_i.t16[20:0]});
  assign t_hi = $signed({1'b0, coef_i.t16[41:21]});

  logic signed [39:0] m1_pc_lo_q, m1_pc_hi_q, m1_ps_lo_q, m1_ps_hi_q;
  sdt_rates_t         m1_tag_q, m2_tag_q;
  logic signed [60:0] m2_tc_q, m2_ts_q;
  logic signed [44:0] m3_full_q, m3_half_q, m3_base_q;
  logic signed [16:0] m3_qd1_q, m3_qd2_q, m3_qs_q;

  logic signed [60:0] tc_rf, tc_rh, ts_rf;
  assign tc_rf = (m2_tc_q + 61'sd32768) >>> 16;
  assign tc_rh = (m2_tc_q + 61'sd65536) >>> 17;
  assign ts_rf = (m2_ts_q + 61'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    m1_pc_lo_q <= 40'(t_lo) * 40'(in_cos_i);
    m1_pc_hi_q <= 40'(t_hi) * 40'(in_cos_i);
    m1_ps_lo_q <= 40'(t_lo) * 40'(in_sin_i);
    m1_ps_hi_q <= 40'(t_hi) * 40'(in_sin_i);
    m1_tag_q   <= in_tag_i;

    m2_tc_q  <= (61'(m1_pc_hi_q) <<< 21) + 61'(m1_pc_lo_q);
    m2_ts_q  <= (61'(m1_ps_hi_q) <<< 21) + 61'(m1_ps_lo_q);
    m2_tag_q <= m1_tag_q;

    m3_full_q <= tc_rf[44:0];
    m3_half_q <= tc_rh[44:0];
    m3_base_q <= ts_rf[44:0];
    m3_qd1_q  <= 17'(m2_tag_q.qd1);
    m3_qd2_q  <= 17'(m2_tag_q.qd2);
    m3_qs_q   <= 17'(m2_tag_q.qd1) + 17'(m2_tag_q.qd2);
  end

  // stage 4: half products of the sine term with the rates
  logic signed [22:0] b_lo, b_hi;
  assign b_lo = $signed({1'b0, m3_base_q[21:0]});
  assign b_hi = m3_base_q[44:22];

  logic signed [39:0] m4_p1_lo_q, m4_p1_hi_q, m4_p2_lo_q, m4_p2_hi_q;
  logic signed [39:0] m4_ps_lo_q, m4_ps_hi_q;
  logic signed [45:0] m4_s11_q, m4_s12_q;
  logic signed [62:0] m5_p1_q, m5_p2_q, m5_ps_q;
  logic signed [31:0] m5_i11_q, m5_i12_q;

  always_ff @(posedge clk_i) begin
    m4_p1_lo_q <= 40'(b_lo) * 40'(m3_qd1_q);
    m4_p1_hi_q <= 40'(b_hi) * 40'(m3_qd1_q);
    m4_p2_lo_q <= 40'(b_lo) * 40'(m3_qd2_q);
    m4_p2_hi_q <= 40'(b_hi) * 40'(m3_qd2_q);
    m4_ps_lo_q <= 40'(b_lo) * 40'(m3_qs_q);
    m4_ps_hi_q <= 40'(b_hi) * 40'(m3_qs_q);
    m4_s11_q   <= 46'($signed({1'b0, coef_i.r_one})) + 46'(m3_full_q);
    m4_s12_q   <= 46'($signed({1'b0, coef_i.r_two})) + 46'(m3_half_q);

    m5_p1_q  <= (63'(m4_p1_hi_q) <<< 22) + 63'(m4_p1_lo_q);
    m5_p2_q  <= (63'(m4_p2_hi_q) <<< 22) + 63'(m4_p2_lo_q);
    m5_ps_q  <= (63'(m4_ps_hi_q) <<< 22) + 63'(m4_ps_lo_q);
    m5_i11_q <= sat32(64'(m4_s11_q));
    m5_i12_q <= sat32(64'(m4_s12_q));
  end

  // stage 6: sign first, then round from Q24 and saturate
  logic signed [62:0] c11_r, c21_r, c12_r;
  assign c11_r = (63'sd128 - m5_p2_q) >>> 8;
  assign c21_r = (m5_p1_q + 63'sd128) >>> 8;
  assign c12_r = (63'sd128 - m5_ps_q) >>> 8;

  always_ff @(posedge clk_i) begin
    out_o.inertia_11  <= m5_i11_q;
    out_o.inertia_22  <= coef_i.inertia_22;
    out_o.inertia_33  <= coef_i.inertia_33;
    out_o.inertia_44  <= coef_i.inertia_44;
    out_o.inertia_12  <= m5_i12_q;
    out_o.inertia_14  <= coef_i.inertia_14;
    out_o.coriolis_11 <= sat32(64'(c11_r));
    out_o.coriolis_21 <= sat32(64'(c21_r));
    out_o.coriolis_12 <= sat32(64'(c12_r));
    out_o.gravity_3   <= coef_i.gravity_3;
  end

endmodule
`default_nettype wire

// ===== rtl/scara_dynamics_terms_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scara_dynamics_terms_unit
// Inertia, Coriolis and gravity terms of a four-joint SCARA arm.
// ----------------------------------------------------------------------------
// Usage:
//   Write the seven Q8.8 registers through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while no item is in flight; derived terms then settle in
//   the coefficient register stages. Pulse start with item_i to issue an item;
//   busy stays low, so an item can be issued every cycle.
//   Each item returns one result on result_o, marked by result_valid_o for
//   a single cycle. It passes through the CORDIC (one stage per
//   micro-rotation plus range reduction and rounding) followed by the
//   six-stage product pipeline. Throughput is one item per cycle.
//   There is no output back-pressure: the receiver must take every result.
//   Reset clears the configuration registers to zero and drops items in
//   flight.
// ----------------------------------------------------------------------------
module scara_dynamics_terms_unit
  import sdt_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
  parameter logic [19:0] GRAVITY_Q16   = GRAVITY_Q16_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  sdt_in_t          item_i,
  output logic             result_valid_o,
  output sdt_out_t         result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned LATENCY = CORDIC_STAGES + 9;

  sdt_coef_t          coef;
  sdt_rates_t         rates_in, rates_out;
  logic               cor_vld;
  logic signed [17:0] sin_v, cos_v;

  assign busy         = 1'b0;
  assign rates_in.qd1 = item_i.joint1_rate;
  assign rates_in.qd2 = item_i.joint2_rate;

  sdt_coef #(
    .GRAVITY_Q16(GRAVITY_Q16)
  ) u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  sdt_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .in_angle_i (item_i.joint2_angle),
    .in_tag_i   (rates_in),
    .out_valid_o(cor_vld),
    .out_sin_o  (sin_v),
    .out_cos_o  (cos_v),
    .out_tag_o  (rates_out)
  );

  sdt_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cor_vld),
    .in_sin_i   (sin_v),
    .in_cos_i   (cos_v),
    .in_tag_i   (rates_out),
    .coef_i     (coef),
    .out_valid_o(result_valid_o),
    .out_o      (result_o)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("item result missing at expected latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##LATENCY !result_valid_o)
    else $error("result without an issued item");

  a_yaw_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.inertia_14 == -result_o.inertia_44))
    else $error("yaw inertia terms disagree");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCARA dynamics terms testbench
// Drives joint angle and rate items with random gaps across several register
// settings, predicts inertia, Coriolis and gravity terms in the bench and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import sdt_pkg::*;

  localparam int          STAGES    = 16;
  localparam longint      GRAV      = 642908;
  localparam longint      PI28      = 843314857;
  localparam longint      TWO_PI28  = 1686629713;
  localparam longint      HALF_PI28 = 421657428;
  localparam int          LATENCY   = STAGES + 9;
  localparam int          SETTLE    = LATENCY + 10;
  localparam int          WATCHDOG  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  sdt_in_t     item_i = '0;
  logic        result_valid_o;
  sdt_out_t    result_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  scara_dynamics_terms_unit uut (.*);

  initial forever #5 clk_i = ~clk_i;

  longint     arm_regs [7];
  sdt_in_t    pending_items [$];
  sdt_out_t   expected_terms [$];
  int         fail_count = 0;
  int         idle_cycles = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Arctangent of 2^-i in Q4.28 from its series, rounded
  function automatic longint arctan_q28(int i);
    longint acc;
    bit     add;
    acc = 0;
    add = 1'b1;
    if (i == 0) return 210828714;
    for (int k = 1; k * i < 60; k += 2) begin
      acc = add ? acc + (longint'(1) << (60 - k * i)) / k
                : acc - (longint'(1) << (60 - k * i)) / k;
      add = !add;
    end
    return (acc + (longint'(1) << 31)) >>> 32;
  endfunction

  task automatic sine_cosine(input logic signed [15:0] ang,
                             output longint s16, output longint c16);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 65536;
    x = 163008219;
    y = 0;
    flip = 1'b0;
    if (z > PI28) z -= TWO_PI28;
    if (z < -PI28) z += TWO_PI28;
    if (z > HALF_PI28) begin
      z = PI28 - z;
      flip = 1'b1;
    end else if (z < -HALF_PI28) begin
      z = -PI28 - z;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q28(i);
      end else begin
        x += dx; y -= dy; z += arctan_q28(i);
      end
    end
    s16 = rshift(y, 12);
    c16 = rshift(x, 12);
    if (flip) c16 = -c16;
  endtask

  task automatic predict_terms(input sdt_in_t it);
    longint   a1, a2, m1, m2, m3, m4, izz, qd1, qd2;
    longint   s16, c16, msum, t16, s_one, s_two, full, half, base;
    sdt_out_t r;
    a1 = arm_regs[0]; a2 = arm_regs[1]; m1 = arm_regs[2]; m2 = arm_regs[3];
    m3 = arm_regs[4]; m4 = arm_regs[5]; izz = arm_regs[6];
    qd1 = it.joint1_rate;
    qd2 = it.joint2_rate;
    sine_cosine(it.joint2_angle, s16, c16);
    msum = m2 + m3 + m4;
    t16 = rshift(a1 * a2 * msum, 8);
    s_two = izz * 65536 + a2 * a2 * msum;
    s_one = s_two + a1 * a1 * (m1 + msum);
    full = rshift(t16 * c16, 16);
    half = rshift(t16 * c16, 17);
    base = rshift(t16 * s16, 16);
    r.inertia_11  = clamp32(rshift(s_one, 9) + full);
    r.inertia_22  = clamp32(rshift(s_two, 9));
    r.inertia_33  = clamp32((m3 + m4) * 128);
    r.inertia_44  = clamp32(izz * 128);
    r.inertia_12  = clamp32(rshift(s_two, 9) + half);
    r.inertia_14  = clamp32(-(izz * 128));
    r.coriolis_11 = clamp32(rshift(-(base * qd2), 8));
    r.coriolis_21 = clamp32(rshift(base * qd1, 8));
    r.coriolis_12 = clamp32(rshift(-(base * (qd1 + qd2)), 8));
    r.gravity_3   = clamp32(rshift(-(GRAV * (m3 + 2 * m4)), 9));
    expected_terms.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, $signed(e), $signed(a));
      fail_count++;
    end
  endtask

  task automatic check_terms(sdt_out_t e, sdt_out_t a);
    check_field("inertia_11", e.inertia_11, a.inertia_11);
    check_field("inertia_22", e.inertia_22, a.inertia_22);
    check_field("inertia_33", e.inertia_33, a.inertia_33);
    check_field("inertia_44", e.inertia_44, a.inertia_44);
    check_field("inertia_12", e.inertia_12, a.inertia_12);
    check_field("inertia_14", e.inertia_14, a.inertia_14);
    check_field("coriolis_11", e.coriolis_11, a.coriolis_11);
    check_field("coriolis_21", e.coriolis_21, a.coriolis_21);
    check_field("coriolis_12", e.coriolis_12, a.coriolis_12);
    check_field("gravity_3", e.gravity_3, a.gravity_3);
  endtask

  // Driver: one item per start, each followed by a random idle gap
  int gap = 0;
  always @(negedge clk_i) begin
    if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0) begin
      item_i <= pending_items.pop_front();
      start <= 1'b1;
      gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, check on each strobe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_terms(item_i);
      end
      if (result_valid_o) begin
        if (expected_terms.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          check_terms(expected_terms.pop_front(), result_o);
        end
      end
      if ((start && !busy) || result_valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(sdt_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < 7) arm_regs[idx] = val;
  endtask

  task automatic load_arm(logic [15:0] a1, logic [15:0] a2, logic [15:0] m1,
                          logic [15:0] m2, logic [15:0] m3, logic [15:0] m4,
                          logic [15:0] izz);
    write_reg(REG_LINK1_LENGTH, a1);
    write_reg(REG_LINK2_LENGTH, a2);
    write_reg(REG_MASS_ONE, m1);
    write_reg(REG_MASS_TWO, m2);
    write_reg(REG_MASS_THREE, m3);
    write_reg(REG_MASS_FOUR, m4);
    write_reg(REG_YAW_INERTIA, izz);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_terms.size() > 0 || start)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic sdt_in_t rand_item();
    sdt_in_t it;
    it.joint2_angle = 16'($urandom);
    it.joint1_rate  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 1023) - 512);
    it.joint2_rate  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 1023) - 512);
    return it;
  endfunction

  function automatic logic [15:0] rand_reg();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  initial begin
    logic signed [15:0] angles [12];
    angles = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sd12868, -16'sd12868,
               16'sd12869, -16'sd12869, 16'sd6434, -16'sd6434, 16'sd6435,
               16'sd25736, -16'sd25736};
    for (int i = 0; i < 7; i++) arm_regs[i] = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // All-zero registers first, then a moderate arm
    pending_items.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    drain();
    load_arm(16'h0100, 16'h00C0, 16'h0200, 16'h0180, 16'h0080, 16'h0040, 16'h0020);
    foreach (angles[i])
      pending_items.push_back('{angles[i], 16'sh0100, -16'sh0080});
    pending_items.push_back('{16'sh1000, 16'sh7FFF, 16'sh7FFF});
    pending_items.push_back('{16'sh1000, -16'sh8000, -16'sh8000});
    pending_items.push_back('{-16'sh1000, -16'sh8000, 16'sh7FFF});
    drain();
    // Saturating extremes
    load_arm(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pending_items.push_back('{16'sd6434, 16'sh7FFF, -16'sh8000});
    pending_items.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
    pending_items.push_back('{-16'sh8000, -16'sh8000, 16'sh7FFF});
    drain();
    // Index beyond the register file is ignored
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'd7;
    cfg_wdata_i <= 16'h1234;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0)
        load_arm(16'h0080, 16'h0060, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0010);
      else
        load_arm(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                 rand_reg(), rand_reg());
      for (int n = 0; n < 150; n++) pending_items.push_back(rand_item());
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
